// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the lfu page replacement unit: frame store
// geometry, field widths, frame access structs and sequencer states.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 20;
    localparam int COUNT_BITS = 16;
    localparam int STAMP_BITS = 32;
    localparam int TOTAL_BITS = 32;
    localparam int ACT_BITS   = 5;
    localparam int IDX_BITS   = $clog2(FRAMES);

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic [PAGE_BITS-1:0]  tag;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_BITS-1:0] stamp;
    } frame_wr_t;

    typedef struct packed {
        logic                  valid;
        logic [PAGE_BITS-1:0]  tag;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_BITS-1:0] stamp;
    } frame_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

endpackage

// ===== rtl/lfu_frame_store.sv =====
// ----------------------------------------------------------------------------
// lfu_frame_store
// Frame table: tag, valid bit, use count and arrival stamp per frame, one
// read port addressed by the scan index and one write port.
// ----------------------------------------------------------------------------
module lfu_frame_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lfu_pkg::IDX_BITS-1:0]      rd_idx,
    output lfu_pkg::frame_rd_t                rd,
    input  lfu_pkg::frame_wr_t                wr
);

    logic [lfu_pkg::FRAMES-1:0]     valid_reg;
    logic [lfu_pkg::PAGE_BITS-1:0]  tag_reg   [lfu_pkg::FRAMES];
    logic [lfu_pkg::COUNT_BITS-1:0] count_reg [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_BITS-1:0] stamp_reg [lfu_pkg::FRAMES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < lfu_pkg::FRAMES; i++)
            begin
                count_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
            count_reg[wr.idx] <= wr.count;
            stamp_reg[wr.idx] <= wr.stamp;
        end
    end

    // tags are only read behind a set valid bit
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_reg[wr.idx] <= wr.tag;
        end
    end

    always_comb
    begin
        rd.valid = valid_reg[rd_idx];
        rd.tag   = tag_reg[rd_idx];
        rd.count = count_reg[rd_idx];
        rd.stamp = stamp_reg[rd_idx];
    end

endmodule

// ===== rtl/lfu_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit
// Fully associative page frame set with least-frequently-used replacement,
// ties broken by earliest arrival then lowest frame index.
//
//   channel | signals                              | dir | accepted when
//   --------+--------------------------------------+-----+---------------------
//   input   | in_valid, in_stall, page             | in  | in_valid & !in_stall
//   output  | out_valid, out_stall, hit, frame_    | out | out_valid & !out_stall
//           | index, evicted, evicted_page, totals |     |
//   config  | cfg_write_en, cfg_write_data         | in  | cfg_write_en
//
// An item is taken in ST_IDLE, then ST_SCAN passes the n live frames (n being the
// active count clamped to 1..16) one frame per cycle through the single compare
// unit, then ST_UPDATE does the write-back.
// Reset clears all frames, counters and the active count to 16; no sweep.
// A held result does not block a new item; write-back waits while it is held.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [lfu_pkg::ACT_BITS-1:0]          cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lfu_pkg::PAGE_BITS-1:0]         page,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic [lfu_pkg::IDX_BITS-1:0]          frame_index,
    output logic                                  evicted,
    output logic [lfu_pkg::PAGE_BITS-1:0]         evicted_page,
    output logic [lfu_pkg::TOTAL_BITS-1:0]        hit_total,
    output logic [lfu_pkg::TOTAL_BITS-1:0]        fault_total,
    output logic [lfu_pkg::TOTAL_BITS-1:0]        refs_total
);

    lfu_pkg::state_t                state_reg, state_next;
    logic [lfu_pkg::ACT_BITS-1:0]   active_reg;
    logic [lfu_pkg::ACT_BITS-1:0]   live_n;
    logic [lfu_pkg::IDX_BITS-1:0]   idx_reg, idx_next;
    logic [lfu_pkg::PAGE_BITS-1:0]  page_reg;

    logic                           found_reg, found_next;
    logic [lfu_pkg::IDX_BITS-1:0]   found_idx_reg, found_idx_next;
    logic [lfu_pkg::COUNT_BITS-1:0] found_count_reg, found_count_next;
    logic [lfu_pkg::STAMP_BITS-1:0] found_stamp_reg, found_stamp_next;
    logic                           empty_reg, empty_next;
    logic [lfu_pkg::IDX_BITS-1:0]   empty_idx_reg, empty_idx_next;
    logic [lfu_pkg::IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [lfu_pkg::COUNT_BITS-1:0] best_count_reg, best_count_next;
    logic [lfu_pkg::STAMP_BITS-1:0] best_stamp_reg, best_stamp_next;
    logic [lfu_pkg::PAGE_BITS-1:0]  best_tag_reg, best_tag_next;

    logic [lfu_pkg::STAMP_BITS-1:0] stamp_ctr_reg;
    logic [lfu_pkg::TOTAL_BITS-1:0] hit_ctr_reg, fault_ctr_reg, ref_ctr_reg;

    logic                           out_valid_reg;
    logic                           hit_reg, evicted_reg;
    logic [lfu_pkg::IDX_BITS-1:0]   frame_index_reg;
    logic [lfu_pkg::PAGE_BITS-1:0]  evicted_page_reg;

    lfu_pkg::frame_rd_t             rd;
    lfu_pkg::frame_wr_t             wr;

    logic in_take, out_take, out_free, scan_last, do_update, better;

    lfu_frame_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (idx_reg),
        .rd     (rd),
        .wr     (wr)
    );

    always_comb
    begin
        if (active_reg == '0)
            live_n = lfu_pkg::ACT_BITS'(1);
        else if (active_reg > lfu_pkg::ACT_BITS'(lfu_pkg::FRAMES))
            live_n = lfu_pkg::ACT_BITS'(lfu_pkg::FRAMES);
        else
            live_n = active_reg;
    end

    assign in_stall  = (state_reg != lfu_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (lfu_pkg::ACT_BITS'(idx_reg) == live_n - lfu_pkg::ACT_BITS'(1));
    assign do_update = (state_reg == lfu_pkg::ST_UPDATE) && out_free;

    // shared compare unit: least count, then earliest stamp
    assign better = (idx_reg == '0) || (rd.count < best_count_reg) ||
                    ((rd.count == best_count_reg) && (rd.stamp < best_stamp_reg));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        found_count_next = found_count_reg;
        found_stamp_next = found_stamp_reg;
        empty_next       = empty_reg;
        empty_idx_next   = empty_idx_reg;
        best_idx_next    = best_idx_reg;
        best_count_next  = best_count_reg;
        best_stamp_next  = best_stamp_reg;
        best_tag_next    = best_tag_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                    idx_next   = '0;
                    found_next = 1'b0;
                    empty_next = 1'b0;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (rd.valid && (rd.tag == page_reg) && !found_reg)
                begin
                    found_next       = 1'b1;
                    found_idx_next   = idx_reg;
                    found_count_next = rd.count;
                    found_stamp_next = rd.stamp;
                end
                if (!rd.valid && !empty_reg)
                begin
                    empty_next     = 1'b1;
                    empty_idx_next = idx_reg;
                end
                if (better)
                begin
                    best_idx_next   = idx_reg;
                    best_count_next = rd.count;
                    best_stamp_next = rd.stamp;
                    best_tag_next   = rd.tag;
                end
                if (scan_last)
                    state_next = lfu_pkg::ST_UPDATE;
                else
                    idx_next = idx_reg + lfu_pkg::IDX_BITS'(1);
            end
            lfu_pkg::ST_UPDATE:
            begin
                if (out_free)
                    state_next = lfu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr.en  = do_update;
        wr.tag = page_reg;
        if (found_reg)
        begin
            wr.idx   = found_idx_reg;
            wr.count = (found_count_reg == '1) ? found_count_reg
                                               : found_count_reg + lfu_pkg::COUNT_BITS'(1);
            wr.stamp = found_stamp_reg;
        end
        else
        begin
            wr.idx   = empty_reg ? empty_idx_reg : best_idx_reg;
            wr.count = lfu_pkg::COUNT_BITS'(1);
            wr.stamp = stamp_ctr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_pkg::ST_IDLE;
            active_reg    <= lfu_pkg::ACT_BITS'(lfu_pkg::FRAMES);
            stamp_ctr_reg <= '0;
            hit_ctr_reg   <= '0;
            fault_ctr_reg <= '0;
            ref_ctr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
                active_reg <= cfg_write_data;
            if (do_update)
            begin
                out_valid_reg <= 1'b1;
                if (ref_ctr_reg != '1)
                    ref_ctr_reg <= ref_ctr_reg + lfu_pkg::TOTAL_BITS'(1);
                if (found_reg)
                begin
                    if (hit_ctr_reg != '1)
                        hit_ctr_reg <= hit_ctr_reg + lfu_pkg::TOTAL_BITS'(1);
                end
                else
                begin
                    if (fault_ctr_reg != '1)
                        fault_ctr_reg <= fault_ctr_reg + lfu_pkg::TOTAL_BITS'(1);
                    if (stamp_ctr_reg != '1)
                        stamp_ctr_reg <= stamp_ctr_reg + lfu_pkg::STAMP_BITS'(1);
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        found_count_reg <= found_count_next;
        found_stamp_reg <= found_stamp_next;
        empty_reg       <= empty_next;
        empty_idx_reg   <= empty_idx_next;
        best_idx_reg    <= best_idx_next;
        best_count_reg  <= best_count_next;
        best_stamp_reg  <= best_stamp_next;
        best_tag_reg    <= best_tag_next;
        if (in_take)
            page_reg <= page;
        if (do_update)
        begin
            hit_reg          <= found_reg;
            frame_index_reg  <= wr.idx;
            evicted_reg      <= !found_reg && !empty_reg;
            evicted_page_reg <= (!found_reg && !empty_reg) ? best_tag_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign frame_index  = frame_index_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;
    assign hit_total    = hit_ctr_reg;
    assign fault_total  = fault_ctr_reg;
    assign refs_total   = ref_ctr_reg;

endmodule

// ===== rtl/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks on the lfu page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  hit,
    input logic [lfu_pkg::IDX_BITS-1:0]          frame_index,
    input logic                                  evicted,
    input logic [lfu_pkg::PAGE_BITS-1:0]         evicted_page,
    input logic [lfu_pkg::TOTAL_BITS-1:0]        refs_total
);

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit item reports an eviction");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_page == '0))
        else $error("evicted page not zero without eviction");

    // an accepted item keeps the input side busy as the scan begins
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall)
        else $error("input taken again too soon");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(refs_total)
                                      && $stable(frame_index)))
        else $error("stalled result changed");

endmodule

bind lfu_page_replacement_unit lfu_checker u_lfu_checker (.*);

// ===== bench/lfu_page_replacement_unit_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit_checker
// Watches the config, input and output channels of the lfu page replacement
// unit. It keeps its own copy of the frame set and counters, works out the
// result of every accepted page reference and compares each accepted result,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [lfu_pkg::ACT_BITS-1:0]   cfg_write_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [lfu_pkg::PAGE_BITS-1:0]  page,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           hit,
    input  logic [lfu_pkg::IDX_BITS-1:0]   frame_index,
    input  logic                           evicted,
    input  logic [lfu_pkg::PAGE_BITS-1:0]  evicted_page,
    input  logic [lfu_pkg::TOTAL_BITS-1:0] hit_total,
    input  logic [lfu_pkg::TOTAL_BITS-1:0] fault_total,
    input  logic [lfu_pkg::TOTAL_BITS-1:0] refs_total,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                           hit;
        logic [lfu_pkg::IDX_BITS-1:0]   frame_index;
        logic                           evicted;
        logic [lfu_pkg::PAGE_BITS-1:0]  evicted_page;
        logic [lfu_pkg::TOTAL_BITS-1:0] hit_total;
        logic [lfu_pkg::TOTAL_BITS-1:0] fault_total;
        logic [lfu_pkg::TOTAL_BITS-1:0] refs_total;
    } page_result_t;

    logic [lfu_pkg::PAGE_BITS-1:0]  frame_page [lfu_pkg::FRAMES];
    logic                           frame_used [lfu_pkg::FRAMES];
    logic [lfu_pkg::COUNT_BITS-1:0] use_freq   [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_BITS-1:0] arrival    [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_BITS-1:0] next_stamp;
    logic [lfu_pkg::TOTAL_BITS-1:0] hits_seen;
    logic [lfu_pkg::TOTAL_BITS-1:0] faults_seen;
    logic [lfu_pkg::TOTAL_BITS-1:0] refs_seen;
    logic [lfu_pkg::ACT_BITS-1:0]   active_setting;
    page_result_t                   owed_results [$];
    int                             mismatches;

    function automatic page_result_t resolve_reference(
        input logic [lfu_pkg::PAGE_BITS-1:0] p);
        page_result_t r;
        int           live;
        int           slot;
        bit           found;
        bit           empty;
        r     = '0;
        live  = int'(active_setting);
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        if (live < 1)
            live = 1;
        if (live > lfu_pkg::FRAMES)
            live = lfu_pkg::FRAMES;
        if (refs_seen != '1)
            refs_seen++;
        for (int j = 0; j < live; j++)
        begin
            if (!found && frame_used[j] && frame_page[j] == p)
            begin
                slot  = j;
                found = 1'b1;
            end
        end
        if (found)
        begin
            if (hits_seen != '1)
                hits_seen++;
            if (use_freq[slot] != '1)
                use_freq[slot]++;
        end
        else
        begin
            if (faults_seen != '1)
                faults_seen++;
            for (int j = 0; j < live; j++)
            begin
                if (!empty && !frame_used[j])
                begin
                    slot  = j;
                    empty = 1'b1;
                end
            end
            if (!empty)
            begin
                // least used, then oldest arrival, then lowest index
                slot = 0;
                for (int j = 1; j < live; j++)
                begin
                    if (use_freq[j] < use_freq[slot] ||
                        (use_freq[j] == use_freq[slot] && arrival[j] < arrival[slot]))
                        slot = j;
                end
                r.evicted      = 1'b1;
                r.evicted_page = frame_page[slot];
            end
            frame_page[slot] = p;
            frame_used[slot] = 1'b1;
            use_freq[slot]   = lfu_pkg::COUNT_BITS'(1);
            arrival[slot]    = next_stamp;
            if (next_stamp != '1)
                next_stamp++;
        end
        r.hit         = found;
        r.frame_index = slot[lfu_pkg::IDX_BITS-1:0];
        r.hit_total   = hits_seen;
        r.fault_total = faults_seen;
        r.refs_total  = refs_seen;
        return r;
    endfunction

    task automatic check_result();
        page_result_t want;
        page_result_t got;
        got.hit          = hit;
        got.frame_index  = frame_index;
        got.evicted      = evicted;
        got.evicted_page = evicted_page;
        got.hit_total    = hit_total;
        got.fault_total  = fault_total;
        got.refs_total   = refs_total;
        if (owed_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result item with none owed: frame=%0d page=%h", $realtime,
                         got.frame_index, got.evicted_page);
        end
        else
        begin
            want = owed_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected hit=%b frame=%0d evicted=%b page=%h totals=%0d/%0d/%0d",
                             want.hit, want.frame_index, want.evicted, want.evicted_page,
                             want.hit_total, want.fault_total, want.refs_total);
                    $display("  actual   hit=%b frame=%0d evicted=%b page=%h totals=%0d/%0d/%0d",
                             got.hit, got.frame_index, got.evicted, got.evicted_page,
                             got.hit_total, got.fault_total, got.refs_total);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < lfu_pkg::FRAMES; j++)
            begin
                frame_used[j] = 1'b0;
                use_freq[j]   = '0;
                arrival[j]    = '0;
            end
            next_stamp     = '0;
            hits_seen      = '0;
            faults_seen    = '0;
            refs_seen      = '0;
            active_setting = lfu_pkg::ACT_BITS'(lfu_pkg::FRAMES);
            mismatches     = 0;
            owed_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
                active_setting = cfg_write_data;
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                owed_results.push_back(resolve_reference(page));
            fail_count  <= mismatches;
            outstanding <= owed_results.size();
        end
    end

endmodule

// ===== bench/lfu_page_replacement_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit_tb
// Drives page references into the lfu page replacement unit: a directed
// fill-and-evict sequence, then phases of skewed random references under
// several active frame counts, with bursty input, patterned output stalls and
// one long output hold-off. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 300;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int POOL_SIZE       = 32;

    typedef enum int {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } stall_pattern_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [lfu_pkg::ACT_BITS-1:0]   cfg_write_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [lfu_pkg::PAGE_BITS-1:0]  page;
    logic                           out_valid;
    logic                           out_stall;
    logic                           hit;
    logic [lfu_pkg::IDX_BITS-1:0]   frame_index;
    logic                           evicted;
    logic [lfu_pkg::PAGE_BITS-1:0]  evicted_page;
    logic [lfu_pkg::TOTAL_BITS-1:0] hit_total;
    logic [lfu_pkg::TOTAL_BITS-1:0] fault_total;
    logic [lfu_pkg::TOTAL_BITS-1:0] refs_total;
    int                             fail_count;
    int                             outstanding;

    int                             burst_left;
    int                             sent_count;
    int                             quiet_cycles;
    logic [lfu_pkg::PAGE_BITS-1:0]  page_pool [POOL_SIZE];

    lfu_page_replacement_unit dut (.*);

    lfu_page_replacement_unit_checker replacement_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic offer_page(input logic [lfu_pkg::PAGE_BITS-1:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        page     = p;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        sent_count++;
        @(negedge clk);
    endtask

    task automatic write_active(input logic [lfu_pkg::ACT_BITS-1:0] v);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = v;
        @(negedge clk);
        cfg_write_en   = 1'b0;
    endtask

    initial
    begin
        int                            working_set;
        int                            pick;
        int                            a;
        int                            b;
        logic [lfu_pkg::PAGE_BITS-1:0] p;
        logic [lfu_pkg::PAGE_BITS-1:0] last_page;
        logic [lfu_pkg::ACT_BITS-1:0]  setting;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        page           = '0;
        burst_left     = 0;
        sent_count     = 0;
        last_page      = '0;
        for (int k = 0; k < POOL_SIZE; k++)
            page_pool[k] = lfu_pkg::PAGE_BITS'($urandom);
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill all frames, extreme pages first, then force lfu evictions
        offer_page('0);
        offer_page('1);
        offer_page('0);
        offer_page('1);
        for (int j = 1; j <= 14; j++)
            offer_page(lfu_pkg::PAGE_BITS'(j * 'h1111));
        offer_page(20'hABCDE);
        offer_page(20'hABCDE);
        offer_page(20'h02222);
        offer_page(20'h5A5A5);
        offer_page(20'h01111);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       setting = 5'd4;
                1:       setting = 5'd1;
                2:       setting = 5'd0;
                3:       setting = 5'd31;
                4:       setting = 5'd2;
                5:       setting = 5'd16;
                6:       setting = 5'd17;
                7:       setting = 5'd7;
                8:       setting = 5'd12;
                default: setting = 5'd3;
            endcase
            write_active(setting);
            working_set = $urandom_range(2, 24);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    // skewed towards the low end of the pool so use counts differ
                    a = $urandom_range(0, working_set - 1);
                    b = $urandom_range(0, working_set - 1);
                    p = page_pool[(a < b) ? a : b];
                end
                else if (pick < 87)
                    p = last_page;
                else
                    p = lfu_pkg::PAGE_BITS'($urandom);
                offer_page(p);
                last_page = p;
            end
            page_pool[$urandom_range(0, POOL_SIZE - 1)] = lfu_pkg::PAGE_BITS'($urandom);
        end

        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        stall_pattern_t flow;
        int             flow_left;
        int             tick;
        bit             hold_done;
        out_stall = 1'b0;
        flow      = FLOW_FREE;
        flow_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (!hold_done && sent_count >= HOLD_AFTER)
            begin
                // long hold-off while the sender keeps offering items
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (flow_left == 0)
                begin
                    flow      = stall_pattern_t'($urandom_range(0, 3));
                    flow_left = $urandom_range(16, 160);
                end
                flow_left--;
                case (flow)
                    FLOW_FREE:  out_stall = 1'b0;
                    FLOW_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
                    default:    out_stall = ((tick % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== filelist.f =====
rtl/lfu_pkg.sv
rtl/lfu_frame_store.sv
rtl/lfu_page_replacement_unit.sv
rtl/lfu_checker.sv
bench/lfu_page_replacement_unit_checker.sv
bench/lfu_page_replacement_unit_tb.sv
